// ===== src/oile_pkg.sv =====
// oile_pkg: shared types, codes and helpers for the ordered integer list engine.
// No dependencies.
package oile_pkg;

  localparam int CmdW  = 3;
  localparam int DataW = 32;
  localparam int StatW = 2;
  localparam int PosW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 3'd0,
    CMD_POP    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_LOOKUP = 3'd4,
    CMD_SORT   = 3'd5,
    CMD_NOP6   = 3'd6,
    CMD_NOP7   = 3'd7
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP_LD,
    S_SCAN_RD,
    S_SCAN_CK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SORT_RDI,
    S_SORT_LDV,
    S_SORT_RDJ,
    S_SORT_CMP,
    S_FIN
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [DataW-1:0]  item;
    logic [PosW-1:0]   position;
    logic              found;
    logic [PosW-1:0]   length;
  } result_t;

  // signed ordering of two raw words
  function automatic logic key_less(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    key_less = $signed(a) < $signed(b);
  endfunction

endpackage

// ===== src/oile_mem.sv =====
// oile_mem: entry store, one write port and one read port, read data registered.
// Depends on oile_pkg.
module oile_mem
  import oile_pkg::*;
#(
  parameter int CAPACITY = 16,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [DataW-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [CAPACITY];
  logic [DataW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/oile_ctrl.sv =====
// oile_ctrl: command sequencer; scans, shifts and sorts the entry store.
// Depends on oile_pkg and oile_mem.
module oile_ctrl
  import oile_pkg::*;
#(
  parameter int CAPACITY = 16,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_busy,
  input  logic [CmdW-1:0]  cmd_code,
  input  logic [DataW-1:0] cmd_value,
  output logic             res_valid,
  input  logic             res_take,
  output result_t          res
);

  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [DataW-1:0] val_r, val_nxt;
  logic [DataW-1:0] v_r, v_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  status_t          status_r, status_nxt;
  logic [DataW-1:0] item_r, item_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic             found_r, found_nxt;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [DataW-1:0] wdata, rdata;
  logic [CW:0]      i_inc;
  logic             i_lt_cnt, i1_lt_cnt;

  oile_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign i_inc     = {1'b0, i_r} + 1'b1;
  assign i_lt_cnt  = i_r < count_r;
  assign i1_lt_cnt = i_inc < {1'b0, count_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (cmd_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (cmd_r)
          CMD_POP:    state_nxt = (count_r == '0) ? S_FIN : S_POP_LD;
          CMD_REMOVE,
          CMD_LOOKUP: state_nxt = S_SCAN_RD;
          CMD_SORT:   state_nxt = S_SORT_RDI;
          default:    state_nxt = S_FIN;
        endcase
      end
      S_POP_LD:   state_nxt = S_SHIFT_RD;
      S_SCAN_RD:  state_nxt = i_lt_cnt ? S_SCAN_CK : S_FIN;
      S_SCAN_CK: begin
        priority if (rdata == val_r) begin
          state_nxt = (cmd_r == CMD_REMOVE) ? S_SHIFT_RD : S_FIN;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = i1_lt_cnt ? S_SHIFT_WR : S_FIN;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_SORT_RDI: state_nxt = i_lt_cnt ? S_SORT_LDV : S_FIN;
      S_SORT_LDV: state_nxt = S_SORT_RDJ;
      S_SORT_RDJ: state_nxt = (j_r != '0) ? S_SORT_CMP : S_SORT_RDI;
      S_SORT_CMP: state_nxt = key_less(v_r, rdata) ? S_SORT_RDJ : S_SORT_RDI;
      S_FIN:      if (res_take) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    v_nxt      = v_r;
    count_nxt  = count_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    status_nxt = status_r;
    item_nxt   = item_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = i_r[AW-1:0];
    raddr      = i_r[AW-1:0];
    wdata      = rdata;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd_t'(cmd_code);
          val_nxt = cmd_value;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        item_nxt   = '0;
        pos_nxt    = '0;
        found_nxt  = 1'b0;
        i_nxt      = '0;
        unique case (cmd_r)
          CMD_APPEND: begin
            if (count_r < CapC) begin
              we        = 1'b1;
              waddr     = count_r[AW-1:0];
              wdata     = val_r;
              count_nxt = count_r + 1'b1;
            end else begin
              status_nxt = ST_FULL;
            end
          end
          CMD_POP: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              item_nxt   = '1;
            end else begin
              re    = 1'b1;
              raddr = '0;
            end
          end
          CMD_CLEAR: count_nxt = '0;
          CMD_SORT:  i_nxt = CW'(1);
          default: ;
        endcase
      end
      S_POP_LD: item_nxt = rdata;
      S_SCAN_RD: begin
        if (i_lt_cnt) begin
          re = 1'b1;
        end else begin
          status_nxt = ST_NOTFOUND;
          if (cmd_r == CMD_LOOKUP) pos_nxt = PosW'(count_r);
        end
      end
      S_SCAN_CK: begin
        if (rdata == val_r) begin
          found_nxt = 1'b1;
          if (cmd_r == CMD_LOOKUP) pos_nxt = PosW'(i_r);
        end else begin
          i_nxt = i_inc[CW-1:0];
        end
      end
      S_SHIFT_RD: begin
        if (i1_lt_cnt) begin
          re    = 1'b1;
          raddr = i_inc[AW-1:0];
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        i_nxt = i_inc[CW-1:0];
      end
      S_SORT_RDI: begin
        if (i_lt_cnt) begin
          re    = 1'b1;
          j_nxt = i_r;
        end
      end
      S_SORT_LDV: v_nxt = rdata;
      S_SORT_RDJ: begin
        if (j_r != '0) begin
          re    = 1'b1;
          raddr = AW'(j_r - 1'b1);
        end else begin
          we    = 1'b1;
          waddr = j_r[AW-1:0];
          wdata = v_r;
          i_nxt = i_inc[CW-1:0];
        end
      end
      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = j_r[AW-1:0];
        if (key_less(v_r, rdata)) begin
          wdata = rdata;
          j_nxt = j_r - 1'b1;
        end else begin
          wdata = v_r;
          i_nxt = i_inc[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    v_r      <= v_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    status_r <= status_nxt;
    item_r   <= item_nxt;
    pos_r    <= pos_nxt;
    found_r  <= found_nxt;
  end

  assign cmd_busy      = state_r != S_IDLE;
  assign res_valid     = state_r == S_FIN;
  assign res.status    = status_r;
  assign res.item      = item_r;
  assign res.position  = pos_r;
  assign res.found     = found_r;
  assign res.length    = PosW'(count_r);

endmodule

// ===== src/ordered_int_list_engine.sv =====
// ordered_int_list_engine: top level; sequencer plus registered result word.
// Depends on oile_pkg and oile_ctrl.
//
//  channel | ports                                            | dir
//  --------+--------------------------------------------------+-----
//  input   | in_valid, in_stall, in_command, in_value         | in
//  result  | out_valid, out_stall, out_status, out_item,      | out
//          | out_position, out_found, out_length              |
//
// One word is worked at a time through a single memory with a registered read.
// Append, clear and unused codes finish from the execute state; lookup and
// remove scan the entries, and remove then shifts the later entries down; pop
// shifts every remaining entry; sort moves elements in an insertion sort.
// Reset empties the list at once; entries are left as they are.
// The result register frees the sequencer; out_stall holds it only at its end.
module ordered_int_list_engine
  import oile_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CmdW-1:0]    in_command,
  input  logic signed [DataW-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [StatW-1:0]   out_status,
  output logic signed [DataW-1:0] out_item,
  output logic [PosW-1:0]    out_position,
  output logic               out_found,
  output logic [PosW-1:0]    out_length
);

  logic    busy, res_valid, res_take;
  result_t res;
  logic    out_valid_r;
  result_t out_r;

  oile_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd_busy  (busy),
    .cmd_code  (in_command),
    .cmd_value (in_value),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign in_stall = busy;
  // result slot is free when empty or being drained this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_item     = out_r.item;
  assign out_position = out_r.position;
  assign out_found    = out_r.found;
  assign out_length   = out_r.length;

endmodule

// ===== bench/ordered_int_list_engine_test.sv =====
// ordered_int_list_engine_test: self-checking bench for the ordered integer list engine.
// Depends on oile_pkg and ordered_int_list_engine; carries its own list predictor.
module ordered_int_list_engine_test;
  import oile_pkg::*;

  localparam int Cap      = 16;
  localparam int RandWords = 1150;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    cmd_t             cmd;
    logic [DataW-1:0] value;
  } cmd_word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CmdW-1:0] in_command;
  logic signed [DataW-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic [StatW-1:0] out_status;
  logic signed [DataW-1:0] out_item;
  logic [PosW-1:0] out_position;
  logic out_found;
  logic [PosW-1:0] out_length;

  ordered_int_list_engine #(.CAPACITY(Cap)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_item(out_item),
    .out_position(out_position), .out_found(out_found),
    .out_length(out_length)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predictor state: a shadow copy of the list.
  logic [DataW-1:0] shadow_list[Cap];
  int unsigned shadow_len;

  cmd_word_t pending_words[$];
  result_t   expected_results[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  logic quiet_stretch;  // no idling on either side while high
  logic stim_done;

  // Applies one command to the shadow list and returns the result it yields.
  function automatic result_t list_apply(input cmd_word_t w);
    result_t r;
    int unsigned hit;
    logic [DataW-1:0] v;
    int j;
    r = '0;
    r.status = ST_OK;
    hit = shadow_len;
    if (w.cmd == CMD_REMOVE || w.cmd == CMD_LOOKUP) begin
      for (int i = shadow_len - 1; i >= 0; i--) begin
        if (shadow_list[i] == w.value) hit = i;
      end
    end
    case (w.cmd)
      CMD_APPEND: begin
        if (shadow_len < Cap) begin
          shadow_list[shadow_len] = w.value;
          shadow_len++;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_POP: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
          r.item = '1;
        end else begin
          r.item = shadow_list[0];
          for (int i = 0; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
        end
      end
      CMD_REMOVE: begin
        if (hit < shadow_len) begin
          for (int i = hit; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
          r.found = 1'b1;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      CMD_CLEAR: shadow_len = 0;
      CMD_LOOKUP: begin
        r.position = hit[PosW-1:0];
        if (hit < shadow_len) r.found = 1'b1;
        else r.status = ST_NOTFOUND;
      end
      CMD_SORT: begin
        // stable insertion sort, signed order
        for (int i = 1; i < shadow_len; i++) begin
          v = shadow_list[i];
          j = i;
          while (j > 0 && $signed(v) < $signed(shadow_list[j - 1])) begin
            shadow_list[j] = shadow_list[j - 1];
            j--;
          end
          shadow_list[j] = v;
        end
      end
      default: ;
    endcase
    r.length = shadow_len[PosW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Value pool: often reuse list members so remove/lookup hit.
  function automatic logic [DataW-1:0] pick_value(input int unsigned len_now);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && len_now > 0) return shadow_list[$urandom_range(0, len_now - 1)];
    if (sel < 7) return DataW'($signed($urandom_range(0, 15)) - 8);
    return $urandom;
  endfunction

  // Word builder: queue word and predict its result right away (one result each).
  task automatic queue_word(input cmd_t c, input logic [DataW-1:0] v);
    cmd_word_t w;
    w.cmd = c;
    w.value = v;
    pending_words.push_back(w);
    expected_results.push_back(list_apply(w));
  endtask

  initial begin
    cmd_t c;
    int unsigned sel;
    shadow_len = 0;
    stim_done = 1'b0;
    // directed: empty cases, extremes, full store, every code
    queue_word(CMD_POP, 32'h0);
    queue_word(CMD_REMOVE, 32'h5);
    queue_word(CMD_LOOKUP, 32'h5);
    queue_word(CMD_SORT, 32'h0);
    queue_word(CMD_APPEND, 32'h7fffffff);
    queue_word(CMD_SORT, 32'h0);
    queue_word(CMD_APPEND, 32'h80000000);
    queue_word(CMD_APPEND, 32'hffffffff);
    queue_word(CMD_APPEND, 32'h00000000);
    queue_word(CMD_APPEND, 32'hffffffff);
    queue_word(CMD_SORT, 32'h0);
    queue_word(CMD_LOOKUP, 32'hffffffff);
    queue_word(CMD_REMOVE, 32'hffffffff);
    queue_word(CMD_NOP6, 32'hffffffff);
    queue_word(CMD_NOP7, 32'h12345678);
    queue_word(CMD_POP, 32'h0);
    for (int i = 0; i < 14; i++) queue_word(CMD_APPEND, $urandom);
    queue_word(CMD_APPEND, 32'h1);  // store full
    queue_word(CMD_SORT, 32'h0);
    queue_word(CMD_CLEAR, 32'h0);
    // random: mostly fill-and-work sequences
    for (int n = 0; n < RandWords; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) c = CMD_APPEND;
      else if (sel < 52) c = CMD_POP;
      else if (sel < 67) c = CMD_REMOVE;
      else if (sel < 70) c = CMD_CLEAR;
      else if (sel < 88) c = CMD_LOOKUP;
      else if (sel < 97) c = CMD_SORT;
      else c = cmd_t'($urandom_range(6, 7));
      queue_word(c, pick_value(shadow_len));
    end
    stim_done = 1'b1;
  end

  // Input driver.
  always @(posedge clk) begin
    cmd_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_command <= '0;
      in_value <= '0;
    end else if (!in_valid || !in_stall) begin
      // previous word taken (or none up): offer the next one or idle
      if (pending_words.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 21)) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_command <= w.cmd;
        in_value <= w.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result word at cycle %0d", cycle_count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_status != want.status)
            report_mismatch("status", DataW'(out_status), DataW'(want.status));
          if (out_item != want.item) report_mismatch("item", out_item, want.item);
          if (out_position != want.position)
            report_mismatch("position", DataW'(out_position), DataW'(want.position));
          if (out_found != want.found)
            report_mismatch("found", DataW'(out_found), DataW'(want.found));
          if (out_length != want.length)
            report_mismatch("length", DataW'(out_length), DataW'(want.length));
        end
      end
      out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 21);
    end
  end

  // Reset, quiet stretch window, end of run and watchdog.
  initial begin
    rst_n = 1'b0;
    quiet_stretch = 1'b0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        wait (stim_done);
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
          @(posedge clk);
        repeat (50) @(posedge clk);
      end
      begin
        while (cycle_count < CycleLimit) begin
          @(posedge clk);
          cycle_count++;
          // no idling for a window in the middle of the run
          quiet_stretch <= (cycle_count > 6000 && cycle_count < 9000);
        end
      end
    join_any
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
    end else if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
